### rtl/core/ppr_pkg.sv
// Shared types and constants for the pair/pack record parser.
`default_nettype none

package ppr_pkg;

  localparam int WORD_W  = 64;
  localparam int PAIR_W  = 5;
  localparam int COUNT_W = 16;

  localparam int PACK_SIZE_DEF = 16;

  // Result queue depth: room for one two-result item plus two in flight.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;

  typedef enum logic [2:0] {
    PH_REC    = 3'd0,
    PH_AFTER  = 3'd1,
    PH_PAIRED = 3'd2,
    PH_TERM   = 3'd3,
    PH_NL     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    K_PAIR = 2'd0,
    K_PACK = 2'd1,
    K_DONE = 2'd2,
    K_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE             = 3'd0,
    E_TRUNC_PAIR       = 3'd1,
    E_TRUNC_PAIRED     = 3'd2,
    E_TOO_MANY         = 3'd3,
    E_BAD_TERM         = 3'd4,
    E_INCOMPLETE       = 3'd5,
    E_INCOMPLETE_FINAL = 3'd6
  } err_t;

  typedef struct packed {
    kind_t               kind;
    logic [WORD_W-1:0]   add_value;
    logic [WORD_W-1:0]   mul_value;
    logic [PAIR_W-1:0]   pair_position;
    logic [COUNT_W-1:0]  pack_count;
    err_t                error_code;
    logic                last_of_run;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/ppr_parse.sv
// Parser state and per-beat result generation.
`default_nettype none

module ppr_parse
  import ppr_pkg::*;
#(
  parameter int PACK_SIZE = PACK_SIZE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic       in_action,
  input  wire logic [7:0] in_data_byte,
  output logic [1:0]      push_cnt,
  output result_t         res0,
  output result_t         res1
);

  localparam logic [PAIR_W-1:0] PackFull = PAIR_W'(PACK_SIZE);

  phase_t              phase_r, phase_nxt;
  logic [3:0]          pos_r, pos_nxt;
  logic [WORD_W-1:0]   first_r, first_nxt;
  logic [WORD_W-1:0]   second_r, second_nxt;
  logic [PAIR_W-1:0]   pairs_r, pairs_nxt;
  logic [COUNT_W-1:0]  packs_r, packs_nxt;
  logic                err_r, err_nxt;

  // Byte-take path: the newline slot starts the record from cleared words.
  logic                src_clear;
  logic [3:0]          src_pos;
  logic [WORD_W-1:0]   src_first, src_second;
  logic [WORD_W-1:0]   lane_byte;
  logic [WORD_W-1:0]   tk_first, tk_second;
  logic                tk_done;
  logic [COUNT_W-1:0]  packs_bump;

  assign src_clear  = (phase_r == PH_NL);
  assign src_pos    = src_clear ? 4'd0 : pos_r;
  assign src_first  = src_clear ? '0 : first_r;
  assign src_second = src_clear ? '0 : second_r;
  assign lane_byte  = {{(WORD_W-8){1'b0}}, in_data_byte} << {src_pos[2:0], 3'b000};
  assign tk_first   = src_pos[3] ? src_first : (src_first | lane_byte);
  assign tk_second  = src_pos[3] ? (src_second | lane_byte) : src_second;
  assign tk_done    = (src_pos == 4'hF);
  assign packs_bump = (packs_r != {COUNT_W{1'b1}}) ? packs_r + COUNT_W'(1) : packs_r;

  always_comb begin
    logic   rec;
    logic   term;
    phase_t rec_next;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    pairs_nxt  = pairs_r;
    packs_nxt  = packs_r;
    err_nxt    = err_r;
    push_cnt   = 2'd0;
    res0       = '0;
    res1       = '0;
    rec        = 1'b0;
    term       = 1'b0;
    rec_next   = PH_AFTER;
    if (in_fire) begin
      if (in_action) begin
        if (!err_r) begin
          if (phase_r == PH_PAIRED) begin
            push_cnt        = 2'd1;
            res0.kind       = K_ERR;
            res0.error_code = E_TRUNC_PAIRED;
          end else if (phase_r == PH_REC && pos_r != 4'd0) begin
            push_cnt        = 2'd1;
            res0.kind       = K_ERR;
            res0.error_code = E_TRUNC_PAIR;
          end else if (pairs_r != '0) begin
            push_cnt = 2'd1;
            if (pairs_r != PackFull) begin
              res0.kind       = K_ERR;
              res0.error_code = E_INCOMPLETE_FINAL;
            end else begin
              packs_nxt = packs_bump;
              res0.kind = K_PACK;
            end
          end
        end
        if (push_cnt == 2'd0) begin
          res0.kind = K_DONE;
          push_cnt  = 2'd1;
        end else begin
          res1.kind = K_DONE;
          push_cnt  = 2'd2;
        end
        // End of file clears everything but the pack total.
        phase_nxt  = PH_REC;
        pos_nxt    = 4'd0;
        first_nxt  = '0;
        second_nxt = '0;
        pairs_nxt  = '0;
        err_nxt    = 1'b0;
      end else if (!err_r) begin
        case (phase_r)
          PH_AFTER: begin
            if (in_data_byte == CH_UNDERSCORE) begin
              phase_nxt  = PH_PAIRED;
              pos_nxt    = 4'd0;
              first_nxt  = '0;
              second_nxt = '0;
            end else begin
              term = 1'b1;
            end
          end
          PH_TERM: term = 1'b1;
          PH_PAIRED: begin
            rec      = 1'b1;
            rec_next = PH_TERM;
          end
          default: begin
            if (phase_r == PH_NL && in_data_byte == CH_NEWLINE) begin
              phase_nxt  = PH_REC;
              pos_nxt    = 4'd0;
              first_nxt  = '0;
              second_nxt = '0;
            end else begin
              rec = 1'b1;
            end
          end
        endcase

        if (rec) begin
          pos_nxt    = src_pos + 4'd1;
          first_nxt  = tk_first;
          second_nxt = tk_second;
          if (tk_done) begin
            phase_nxt = rec_next;
            push_cnt  = 2'd1;
            if (pairs_r >= PackFull) begin
              err_nxt         = 1'b1;
              res0.kind       = K_ERR;
              res0.error_code = E_TOO_MANY;
            end else begin
              pairs_nxt          = pairs_r + PAIR_W'(1);
              res0.kind          = K_PAIR;
              res0.add_value     = tk_first;
              res0.mul_value     = tk_second;
              res0.pair_position = pairs_r + PAIR_W'(1);
            end
          end else begin
            phase_nxt = (phase_r == PH_PAIRED) ? PH_PAIRED : PH_REC;
          end
        end

        if (term) begin
          if (in_data_byte == CH_AT) begin
            push_cnt = 2'd1;
            if (pairs_r != PackFull) begin
              err_nxt         = 1'b1;
              res0.kind       = K_ERR;
              res0.error_code = E_INCOMPLETE;
            end else begin
              packs_nxt = packs_bump;
              pairs_nxt = '0;
              phase_nxt = PH_NL;
              res0.kind = K_PACK;
            end
          end else if (in_data_byte == CH_DOLLAR) begin
            phase_nxt = PH_NL;
          end else begin
            push_cnt        = 2'd1;
            err_nxt         = 1'b1;
            res0.kind       = K_ERR;
            res0.error_code = E_BAD_TERM;
          end
        end
      end
    end

    // Only error results from an end of file latch nothing; data-path errors did above.
    if (in_fire && in_action && push_cnt == 2'd2) begin
      res0.last_of_run = 1'b0;
      res1.last_of_run = 1'b1;
    end else begin
      res0.last_of_run = 1'b1;
    end
    res0.pack_count = packs_nxt;
    res1.pack_count = packs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_REC;
      pos_r    <= 4'd0;
      first_r  <= '0;
      second_r <= '0;
      pairs_r  <= '0;
      packs_r  <= '0;
      err_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      pairs_r  <= pairs_nxt;
      packs_r  <= packs_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ppr_result_fifo.sv
// Small result queue: takes up to two results per cycle, delivers one per cycle unless stalled.
`default_nettype none

module ppr_result_fifo
  import ppr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic [1:0] push_cnt,
  input  wire result_t din0,
  input  wire result_t din1,
  output logic         full2,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      dout
);

  localparam int CNT_W = FIFO_AW + 1;

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt, wr_inc;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign dout      = mem[rd_r];
  // Hold the input side until two free slots are guaranteed.
  assign full2     = (count_r > CNT_W'(FIFO_DEPTH - 2));
  assign wr_inc    = wr_r + FIFO_AW'(1);

  always_comb begin
    wr_nxt    = wr_r + FIFO_AW'(push_cnt);
    rd_nxt    = pop ? rd_r + FIFO_AW'(1) : rd_r;
    count_nxt = count_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_r] <= din0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_inc] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/pair_pack_record_parser.sv
// Byte-stream parser for add/mul pair records grouped into packs.
//
// Input channel (in_valid/in_stall): one beat per file byte (in_action = 0)
// or an end-of-file marker (in_action = 1). A beat is taken when in_valid is
// high and in_stall is low. Output channel (out_valid/out_stall) carries the
// results: pairs, pack completions, file done and errors, with out_last_of_run
// set on the last result caused by one input beat.
// A result is presented in the cycle after the beat that caused it when no
// older result is still waiting in the queue. One input beat is taken per
// cycle while in_stall is low; a data byte yields at most one result, an
// end-of-file beat yields one or two, which the four-entry result queue
// absorbs. in_stall rises only when fewer than two queue slots are free.
// When the receiver stalls, the queue fills and then stalls the sender;
// nothing is dropped. Synchronous reset (rst_n low) clears the parser state,
// the pack total and the queue. An error is sticky: later data bytes give no
// result until the end-of-file beat, which clears all but the pack total.
`default_nettype none

module pair_pack_record_parser
  import ppr_pkg::*;
#(
  parameter int PACK_SIZE = PACK_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_action,
  input  wire logic [7:0]         in_data_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_kind,
  output logic [WORD_W-1:0]       out_add_value,
  output logic [WORD_W-1:0]       out_mul_value,
  output logic [PAIR_W-1:0]       out_pair_position,
  output logic [COUNT_W-1:0]      out_pack_count,
  output logic [2:0]              out_error_code,
  output logic                    out_last_of_run
);

  logic       in_fire;
  logic [1:0] push_cnt;
  result_t    res0, res1, head;

  assign in_fire = in_valid && !in_stall;

  ppr_parse #(
    .PACK_SIZE (PACK_SIZE)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .push_cnt     (push_cnt),
    .res0         (res0),
    .res1         (res1)
  );

  ppr_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .din0      (res0),
    .din1      (res1),
    .full2     (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (head)
  );

  assign out_kind          = head.kind;
  assign out_add_value     = head.add_value;
  assign out_mul_value     = head.mul_value;
  assign out_pair_position = head.pair_position;
  assign out_pack_count    = head.pack_count;
  assign out_error_code    = head.error_code;
  assign out_last_of_run   = head.last_of_run;

endmodule

`default_nettype wire

### dv/pair_pack_record_parser_tb.sv
// Self-checking testbench for the pair/pack record parser: byte streams in, results checked.
`timescale 1ns / 1ps

module pair_pack_record_parser_tb
  import ppr_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_BEATS = 1300;

  typedef struct packed {
    logic       act;
    logic [7:0] b;
  } beat_t;

  // Tracks the parser state and holds the results it must produce, oldest first.
  class record_scoreboard;
    localparam int PACK = PACK_SIZE_DEF;

    phase_t             phase;
    logic [3:0]         byte_pos;
    logic [WORD_W-1:0]  word_add;
    logic [WORD_W-1:0]  word_mul;
    int                 pairs;
    logic [COUNT_W-1:0] packs;
    bit                 err_latched;
    result_t            staged[$];
    result_t            expected_results[$];
    int                 failures;

    function new();
      phase = PH_REC;
      byte_pos = '0;
      word_add = '0;
      word_mul = '0;
      pairs = 0;
      packs = '0;
      err_latched = 1'b0;
      failures = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void emit(kind_t k, logic [WORD_W-1:0] a, logic [WORD_W-1:0] m,
                       logic [PAIR_W-1:0] pos, err_t e);
      result_t r;
      r.kind = k;
      r.add_value = a;
      r.mul_value = m;
      r.pair_position = pos;
      r.pack_count = packs;
      r.error_code = e;
      r.last_of_run = 1'b0;
      staged = {staged, r};
    endfunction

    function void raise_error(err_t e);
      err_latched = 1'b1;
      emit(K_ERR, '0, '0, '0, e);
    endfunction

    function void bump_packs();
      if (packs != '1) packs++;
    endfunction

    function void clear_words();
      byte_pos = '0;
      word_add = '0;
      word_mul = '0;
    endfunction

    function void record_byte(logic [7:0] b, phase_t next);
      logic [3:0] pos;
      pos = byte_pos;
      if (pos < 8) word_add = word_add | (64'(b) << (8 * pos));
      else word_mul = word_mul | (64'(b) << (8 * (pos - 8)));
      byte_pos = pos + 4'd1;
      if (pos == 4'd15) begin
        if (pairs >= PACK) begin
          raise_error(E_TOO_MANY);
        end else begin
          pairs++;
          emit(K_PAIR, word_add, word_mul, PAIR_W'(pairs), E_NONE);
        end
        phase = next;
      end
    endfunction

    function void terminator(logic [7:0] b);
      if (b == CH_AT) begin
        if (pairs != PACK) begin
          raise_error(E_INCOMPLETE);
        end else begin
          bump_packs();
          pairs = 0;
          phase = PH_NL;
          emit(K_PACK, '0, '0, '0, E_NONE);
        end
      end else if (b == CH_DOLLAR) begin
        phase = PH_NL;
      end else begin
        raise_error(E_BAD_TERM);
      end
    endfunction

    function void end_of_file();
      if (!err_latched) begin
        if (phase == PH_PAIRED) begin
          raise_error(E_TRUNC_PAIRED);
        end else if (phase == PH_REC && byte_pos != 0) begin
          raise_error(E_TRUNC_PAIR);
        end else if (pairs != 0) begin
          if (pairs != PACK) begin
            raise_error(E_INCOMPLETE_FINAL);
          end else begin
            bump_packs();
            emit(K_PACK, '0, '0, '0, E_NONE);
          end
        end
      end
      emit(K_DONE, '0, '0, '0, E_NONE);
      phase = PH_REC;
      clear_words();
      pairs = 0;
      err_latched = 1'b0;
    endfunction

    function void note_beat(logic act, logic [7:0] b);
      staged.delete();
      if (act) begin
        end_of_file();
      end else if (!err_latched) begin
        case (phase)
          PH_NL: begin
            phase = PH_REC;
            clear_words();
            // anything but a newline already belongs to the next record
            if (b != CH_NEWLINE) record_byte(b, PH_AFTER);
          end
          PH_AFTER: begin
            if (b == CH_UNDERSCORE) begin
              phase = PH_PAIRED;
              clear_words();
            end else begin
              terminator(b);
            end
          end
          PH_PAIRED: record_byte(b, PH_TERM);
          PH_TERM: terminator(b);
          default: begin
            phase = PH_REC;
            record_byte(b, PH_AFTER);
          end
        endcase
      end
      if (staged.size() > 0) staged[staged.size()-1].last_of_run = 1'b1;
      foreach (staged[i]) expected_results = {expected_results, staged[i]};
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d", got.kind);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("add_value", want.add_value, got.add_value);
      check_field("mul_value", want.mul_value, got.mul_value);
      check_field("pair_position", want.pair_position, got.pair_position);
      check_field("pack_count", want.pack_count, got.pack_count);
      check_field("error_code", want.error_code, got.error_code);
      check_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic [7:0]         in_data_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_kind;
  logic [WORD_W-1:0]  out_add_value;
  logic [WORD_W-1:0]  out_mul_value;
  logic [PAIR_W-1:0]  out_pair_position;
  logic [COUNT_W-1:0] out_pack_count;
  logic [2:0]         out_error_code;
  logic               out_last_of_run;

  record_scoreboard sb = new();
  beat_t            stimulus[$];
  int               beats_taken = 0;
  int               cycle_count = 0;
  result_t          observed;

  pair_pack_record_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_add_value    (out_add_value),
    .out_mul_value    (out_mul_value),
    .out_pair_position(out_pair_position),
    .out_pack_count   (out_pack_count),
    .out_error_code   (out_error_code),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pair_pack_record_parser regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_beat(in_action, in_data_byte);
        beats_taken++;
      end
      if (out_valid && !out_stall) begin
        observed.kind = kind_t'(out_kind);
        observed.add_value = out_add_value;
        observed.mul_value = out_mul_value;
        observed.pair_position = out_pair_position;
        observed.pack_count = out_pack_count;
        observed.error_code = err_t'(out_error_code);
        observed.last_of_run = out_last_of_run;
        sb.check_result(observed);
      end
    end
  end

  // Receiver: stall in changing modes, with one long hold-off once traffic is flowing.
  initial begin
    int  mode;
    int  mode_left;
    bit  held;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (!held && beats_taken >= 400) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 15);
          2: out_stall <= ($urandom_range(0, 99) < 60);
          default: out_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_beat(logic act, logic [7:0] b);
    beat_t x;
    x.act = act;
    x.b = b;
    stimulus = {stimulus, x};
  endtask

  task automatic put_eof();
    put_beat(1'b1, pick_byte());
  endtask

  task automatic put_word(logic [63:0] w);
    for (int i = 0; i < 8; i++) put_beat(1'b0, w[8*i +: 8]);
  endtask

  task automatic put_record(int nbytes);
    repeat (nbytes) put_beat(1'b0, pick_byte());
  endtask

  // Emit a pack of the given pair count; the last group closes with last_term.
  task automatic put_pack(int npairs, logic [7:0] last_term);
    int left;
    left = npairs;
    while (left > 0) begin
      put_record(16);
      left--;
      if (left > 0 && $urandom_range(0, 2) == 0) begin
        put_beat(1'b0, CH_UNDERSCORE);
        put_record(16);
        left--;
      end
      put_beat(1'b0, (left == 0) ? last_term : CH_DOLLAR);
      if ($urandom_range(0, 1)) put_beat(1'b0, CH_NEWLINE);
    end
  endtask

  task automatic put_random_file();
    int         sel;
    logic [7:0] bad;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      if ($urandom_range(0, 1)) put_pack(16, CH_AT);
      case ($urandom_range(0, 2))
        0: ;
        1: put_pack($urandom_range(1, 15), CH_DOLLAR);
        default: put_pack(16, CH_DOLLAR);
      endcase
    end else if (sel < 65) begin
      put_pack(17, CH_AT);
      put_record($urandom_range(0, 20));
    end else if (sel < 75) begin
      put_pack($urandom_range(1, 15), CH_AT);
      put_record($urandom_range(0, 20));
    end else if (sel < 84) begin
      do bad = 8'($urandom_range(0, 255));
      while (bad == CH_AT || bad == CH_DOLLAR || bad == CH_UNDERSCORE);
      put_pack($urandom_range(1, 4), bad);
      put_record($urandom_range(0, 10));
    end else if (sel < 94) begin
      if ($urandom_range(0, 1)) put_pack($urandom_range(1, 3), CH_DOLLAR);
      if ($urandom_range(0, 1)) begin
        put_record($urandom_range(1, 15));
      end else begin
        put_record(16);
        put_beat(1'b0, CH_UNDERSCORE);
        put_record($urandom_range(0, 15));
      end
    end else begin
      put_record($urandom_range(1, 40));
    end
    put_eof();
  endtask

  task automatic send_beat(logic act, logic [7:0] b);
    in_valid <= 1'b1;
    in_action <= act;
    in_data_byte <= b;
    do @(posedge clk);
    while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    int burst_left;
    int gap;
    in_valid <= 1'b0;
    in_action <= 1'b0;
    in_data_byte <= 8'h00;
    rst_n <= 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // empty file, then a short partial record
    put_eof();
    put_beat(1'b0, 8'h00);
    put_beat(1'b0, 8'hFF);
    put_beat(1'b0, 8'h5A);
    put_eof();
    // paired record cut off right after the underscore
    put_word('1);
    put_word('0);
    put_beat(1'b0, CH_UNDERSCORE);
    put_eof();
    // bad terminator; the byte after it is dropped
    put_word(64'h0123_4567_89AB_CDEF);
    put_word(64'h8000_0000_0000_0001);
    put_beat(1'b0, 8'h23);
    put_beat(1'b0, CH_AT);
    put_eof();
    // pack closed too early
    put_word({$urandom(), $urandom()});
    put_word({$urandom(), $urandom()});
    put_beat(1'b0, CH_AT);
    put_eof();
    // newline and no-newline slots, then an open pack at end of file
    put_record(16);
    put_beat(1'b0, CH_DOLLAR);
    put_beat(1'b0, CH_NEWLINE);
    put_record(16);
    put_beat(1'b0, CH_DOLLAR);
    put_record(16);
    put_beat(1'b0, CH_UNDERSCORE);
    put_record(16);
    put_beat(1'b0, CH_DOLLAR);
    put_eof();

    while (stimulus.size() < ITEM_BEATS) put_random_file();

    burst_left = 0;
    for (int i = 0; i < stimulus.size(); i++) begin
      send_beat(stimulus[i].act, stimulus[i].b);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end else begin
        burst_left--;
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("pair_pack_record_parser regression: pass");
    end else begin
      $display("pair_pack_record_parser regression: fail");
    end
    $finish;
  end

endmodule
